/* hw/rtl/psba_pkg.sv */
`default_nettype none

package psba_pkg;

  // default number of page slots
  localparam int unsigned MaxPagesDefault = 4096;

  // bitmap memory word
  localparam int unsigned WordBits = 64;
  localparam int unsigned BitIdxW  = $clog2(WordBits);

  // fixed field widths
  localparam int unsigned ActionW = 3;
  localparam int unsigned PageW   = 13;
  localparam int unsigned StatusW = 2;

  // action codes
  typedef enum logic [ActionW-1:0] {
    ActAlloc = 3'd0,
    ActFree  = 3'd1,
    ActCheck = 3'd2,
    ActLast  = 3'd3,
    ActClear = 3'd4
  } action_e;

  // status codes
  typedef enum logic [StatusW-1:0] {
    StatOk      = 2'd0,
    StatInvalid = 2'd1,
    StatFull    = 2'd2
  } status_e;

  // request word
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [PageW-1:0]   page_number;
  } in_word_t;

  // response word
  typedef struct packed {
    logic [PageW-1:0]   result_page;
    logic               appended;
    logic [StatusW-1:0] status;
  } out_word_t;

  // bitmap memory command strobes
  typedef struct packed {
    logic ren;
    logic wen;
    logic clr;
  } mem_cmd_t;

  // index of the lowest set bit, zero when none
  function automatic logic [BitIdxW-1:0] lowest_set(input logic [WordBits-1:0] v);
    logic [BitIdxW-1:0] idx;
    idx = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (v[i]) idx = BitIdxW'(i);
    end
    return idx;
  endfunction

  // index of the highest set bit, zero when none
  function automatic logic [BitIdxW-1:0] highest_set(input logic [WordBits-1:0] v);
    logic [BitIdxW-1:0] idx;
    idx = '0;
    for (int i = 0; i < WordBits; i++) begin
      if (v[i]) idx = BitIdxW'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/psba_mem.sv */
`default_nettype none

module psba_mem #(
  parameter int unsigned MaxPages = psba_pkg::MaxPagesDefault,
  localparam int unsigned NumWords =
    (MaxPages + psba_pkg::WordBits - 1) / psba_pkg::WordBits,
  localparam int unsigned AddrW = (NumWords > 1) ? $clog2(NumWords) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire psba_pkg::mem_cmd_t            cmd_i,
  input  wire logic [AddrW-1:0]              raddr_i,
  input  wire logic [AddrW-1:0]              waddr_i,
  input  wire logic [psba_pkg::WordBits-1:0] wdata_i,
  output logic      [psba_pkg::WordBits-1:0] rdata_o
);
  import psba_pkg::*;

  logic [WordBits-1:0] mem_q [NumWords];
  logic [WordBits-1:0] rdata_q;
  logic [NumWords-1:0] vld_q;
  logic                rd_vld_q;
  logic                fwd;

  // same-word write and read in one cycle: forward the new word
  assign fwd = cmd_i.wen && (waddr_i == raddr_i);

  // bitmap words, one write and one read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wen) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (cmd_i.ren) begin
      rdata_q <= fwd ? wdata_i : mem_q[raddr_i];
    end
  end

  // per-word written flags, cleared at reset and by a clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        vld_q <= '0;
      end else if (cmd_i.wen) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (cmd_i.ren) begin
        rd_vld_q <= fwd ? 1'b1 : vld_q[raddr_i];
      end
    end
  end

  // a word never written since reset or clear reads as empty
  assign rdata_o = rd_vld_q ? rdata_q : '0;

endmodule

`default_nettype wire

/* hw/rtl/psba_ctrl.sv */
`default_nettype none

module psba_ctrl #(
  parameter int unsigned MaxPages = psba_pkg::MaxPagesDefault,
  localparam int unsigned NumWords =
    (MaxPages + psba_pkg::WordBits - 1) / psba_pkg::WordBits,
  localparam int unsigned AddrW = (NumWords > 1) ? $clog2(NumWords) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire psba_pkg::in_word_t            in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output psba_pkg::out_word_t                out_word_o,
  output psba_pkg::mem_cmd_t                 mem_cmd_o,
  output logic      [AddrW-1:0]              mem_raddr_o,
  output logic      [AddrW-1:0]              mem_waddr_o,
  output logic      [psba_pkg::WordBits-1:0] mem_wdata_o,
  input  wire logic [psba_pkg::WordBits-1:0] mem_rdata_i
);
  import psba_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxPages + 1);
  localparam int unsigned ExtW  = CntW + BitIdxW + 1;
  localparam int unsigned SlotW = AddrW + BitIdxW + 1;
  localparam int unsigned CmpW  = (CntW > PageW) ? CntW : PageW;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StScanUp = 5'b00010,
    StScanDn = 5'b00100,
    StPick   = 5'b01000,
    StHold   = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [AddrW-1:0]    w_q, w_d;
  logic [ActionW-1:0]  act_q, act_d;
  logic [PageW-1:0]    page_q, page_d;
  out_word_t           res_q, res_d;
  out_word_t           out_word_q;
  logic                out_valid_q;
  logic                out_load;

  logic [ExtW-1:0]     lim;
  logic [WordBits-1:0] up_mask;
  logic [WordBits-1:0] free_bits;
  logic                more_up;
  logic [BitIdxW-1:0]  apnd_bit;
  logic [AddrW-1:0]    apnd_word;
  logic                in_range;
  logic [PageW-1:0]    in_slot;
  logic [PageW-1:0]    pick_slot;
  logic [BitIdxW-1:0]  pick_bit;
  logic [BitIdxW-1:0]  up_bit;
  logic [BitIdxW-1:0]  dn_bit;

  // slots of the current word that lie below the page count
  assign lim     = ExtW'(cnt_q) - (ExtW'(w_q) << BitIdxW);
  assign up_mask = (lim >= ExtW'(WordBits)) ? '1
                 : ((WordBits'(1) << lim[BitIdxW-1:0]) - WordBits'(1));
  assign free_bits = ~mem_rdata_i & up_mask;
  assign more_up   = ((ExtW'(w_q) + ExtW'(1)) << BitIdxW) < ExtW'(cnt_q);
  assign up_bit    = lowest_set(free_bits);
  assign dn_bit    = highest_set(mem_rdata_i);

  // append position: slot at the page count
  assign apnd_bit  = BitIdxW'(cnt_q);
  assign apnd_word = AddrW'(cnt_q >> BitIdxW);

  // page number bound check and slot of the addressed page
  assign in_range = (in_word_i.page_number != '0) &&
                    (CmpW'(in_word_i.page_number) <= CmpW'(cnt_q));
  assign in_slot   = in_word_i.page_number - PageW'(1);
  assign pick_slot = page_q - PageW'(1);
  assign pick_bit  = pick_slot[BitIdxW-1:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    w_d         = w_q;
    act_d       = act_q;
    page_d      = page_q;
    res_d       = res_q;
    out_load    = 1'b0;
    mem_cmd_o   = '0;
    mem_raddr_o = '0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          act_d   = in_word_i.action;
          page_d  = in_word_i.page_number;
          res_d   = '0;
          state_d = StHold;
          unique case (in_word_i.action)
            ActAlloc, ActLast: begin
              if (cnt_q == '0) begin
                // empty store: first page appended straight away
                mem_cmd_o.wen = 1'b1;
                mem_waddr_o   = '0;
                mem_wdata_o   = WordBits'(1);
                cnt_d         = CntW'(1);
                res_d.result_page = PageW'(1);
                res_d.appended    = 1'b1;
              end else begin
                mem_cmd_o.ren = 1'b1;
                if (in_word_i.action == ActAlloc) begin
                  mem_raddr_o = '0;
                  state_d     = StScanUp;
                end else begin
                  mem_raddr_o = AddrW'((cnt_q - CntW'(1)) >> BitIdxW);
                  state_d     = StScanDn;
                end
                w_d = mem_raddr_o;
              end
            end
            ActFree, ActCheck: begin
              if (in_range) begin
                mem_cmd_o.ren = 1'b1;
                mem_raddr_o   = AddrW'(in_slot >> BitIdxW);
                state_d       = StPick;
              end else begin
                res_d.status = StatInvalid;
              end
            end
            ActClear: begin
              mem_cmd_o.clr = 1'b1;
            end
            default: begin
              res_d.status = StatInvalid;
            end
          endcase
        end
      end

      StScanUp: begin
        if (free_bits != '0) begin
          // first free slot below the count
          mem_cmd_o.wen = 1'b1;
          mem_waddr_o   = w_q;
          mem_wdata_o   = mem_rdata_i | (WordBits'(1) << up_bit);
          res_d.result_page = PageW'(SlotW'({w_q, up_bit}) + SlotW'(1));
          state_d = StHold;
        end else if (more_up) begin
          mem_cmd_o.ren = 1'b1;
          mem_raddr_o   = w_q + AddrW'(1);
          w_d           = mem_raddr_o;
        end else if (cnt_q == CntW'(MaxPages)) begin
          res_d.status = StatFull;
          state_d      = StHold;
        end else begin
          // append; a word starting at the count holds no used slot yet
          mem_cmd_o.wen = 1'b1;
          mem_waddr_o   = apnd_word;
          mem_wdata_o   = ((apnd_bit == '0) ? '0 : mem_rdata_i) |
                          (WordBits'(1) << apnd_bit);
          cnt_d         = cnt_q + CntW'(1);
          res_d.result_page = PageW'(cnt_q + CntW'(1));
          res_d.appended    = 1'b1;
          state_d = StHold;
        end
      end

      StScanDn: begin
        if (mem_rdata_i != '0) begin
          res_d.result_page = PageW'(SlotW'({w_q, dn_bit}) + SlotW'(1));
          state_d = StHold;
        end else if (w_q != '0) begin
          mem_cmd_o.ren = 1'b1;
          mem_raddr_o   = w_q - AddrW'(1);
          w_d           = mem_raddr_o;
        end else begin
          // nothing used: allocation takes slot zero
          mem_cmd_o.wen = 1'b1;
          mem_waddr_o   = '0;
          mem_wdata_o   = WordBits'(1);
          res_d.result_page = PageW'(1);
          state_d = StHold;
        end
      end

      StPick: begin
        if (mem_rdata_i[pick_bit]) begin
          if (act_q == ActFree) begin
            mem_cmd_o.wen = 1'b1;
            mem_waddr_o   = AddrW'(pick_slot >> BitIdxW);
            mem_wdata_o   = mem_rdata_i & ~(WordBits'(1) << pick_bit);
          end
          res_d.result_page = page_q;
        end else begin
          res_d.status = StatInvalid;
        end
        state_d = StHold;
      end

      StHold: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    act_q  <= act_d;
    page_q <= page_d;
    res_q  <= res_d;
    if (out_load) begin
      out_word_q <= res_q;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

/* hw/rtl/page_slot_bitmap_allocator.sv */
// First-fit page allocator over a used-page bitmap held in one synchronous
// memory of 64-bit words (one bit per page slot) plus a page count. Requests
// are handled one at a time and the response sits in an output register, so
// the next request is taken while a response still waits. Allocate scans
// memory words upward at one word per cycle; last-valid scans downward from
// the word that holds the last slot below the count. Free and check read one
// word. All scans go through the single read port. A request finishes only
// once the output register is free, so an unread response holds up the
// request that follows it. Each memory word carries a written flag in
// flip-flops, so reset and clear empty the bitmap at once with no clearing
// pass.
`default_nettype none

module page_slot_bitmap_allocator #(
  parameter int unsigned MaxPages = psba_pkg::MaxPagesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire psba_pkg::in_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output psba_pkg::out_word_t     out_word_o
);
  import psba_pkg::*;

  localparam int unsigned NumWords = (MaxPages + WordBits - 1) / WordBits;
  localparam int unsigned AddrW    = (NumWords > 1) ? $clog2(NumWords) : 1;

  mem_cmd_t            mem_cmd;
  logic [AddrW-1:0]    mem_raddr;
  logic [AddrW-1:0]    mem_waddr;
  logic [WordBits-1:0] mem_wdata;
  logic [WordBits-1:0] mem_rdata;

  // request sequencer and response register
  psba_ctrl #(
    .MaxPages (MaxPages)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .mem_cmd_o   (mem_cmd),
    .mem_raddr_o (mem_raddr),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  // used-page bitmap
  psba_mem #(
    .MaxPages (MaxPages)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (mem_cmd),
    .raddr_i (mem_raddr),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/psba_checker.sv */
`default_nettype none

module psba_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire psba_pkg::in_word_t  in_word_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire psba_pkg::out_word_t out_word_o
);
  import psba_pkg::*;

  // a waiting request holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i))
    else $error("request dropped or changed while waiting");

  // a pending response holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("response dropped or changed while stalled");

  // the block is never ready in the cycle after it takes a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken on back-to-back cycles");

  // an appended page is a successful allocation of a real page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.appended |->
      out_word_o.status == StatOk && out_word_o.result_page != '0)
    else $error("append reported with bad status or page");

  // an error response carries no page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != StatOk |->
      out_word_o.result_page == '0 && !out_word_o.appended)
    else $error("error response carries a page");

endmodule

bind page_slot_bitmap_allocator psba_checker u_psba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  import psba_pkg::*;

  localparam int unsigned MaxPages   = MaxPagesDefault;
  localparam int unsigned RandWords  = 820;
  localparam int unsigned IdlePct    = 38;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned TailCycles = 80;

  // clock, reset and block ports
  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  // pending requests and responses still owed by the block
  in_word_t  req_q[$];
  out_word_t resp_q[$];

  // shadow copy of the bitmap and page count
  bit [MaxPages-1:0] used_map;
  int unsigned       pg_count;

  int unsigned n_in;
  int unsigned mismatch_cnt;
  int unsigned stall_cycles;
  logic        calm;

  page_slot_bitmap_allocator #(
    .MaxPages (MaxPages)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // reset asserted at start, then released
  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // no idling on either side for a stretch of words
  assign calm = (n_in >= 300) && (n_in < 420);

  // first-fit allocation on the shadow bitmap, append when nothing is free
  function automatic out_word_t take_page();
    out_word_t r;
    int unsigned i;
    r = '0;
    for (i = 0; i < pg_count; i++) begin
      if (!used_map[i]) begin
        used_map[i]   = 1'b1;
        r.result_page = PageW'(i + 1);
        r.status      = StatOk;
        return r;
      end
    end
    if (pg_count >= MaxPages) begin
      r.status = StatFull;
      return r;
    end
    used_map[pg_count] = 1'b1;
    pg_count++;
    r.result_page = PageW'(pg_count);
    r.appended    = 1'b1;
    r.status      = StatOk;
    return r;
  endfunction

  // page in range and in use
  function automatic bit page_live(logic [PageW-1:0] p);
    if (p == '0 || p > pg_count || p > MaxPages) return 1'b0;
    return used_map[p - 1];
  endfunction

  // expected response for one request, updates the shadow state
  function automatic out_word_t serve_request(in_word_t w);
    out_word_t   r;
    int unsigned i;
    r = '0;
    case (w.action)
      ActAlloc: r = take_page();
      ActFree: begin
        if (page_live(w.page_number)) begin
          used_map[w.page_number - 1] = 1'b0;
          r.result_page = w.page_number;
          r.status      = StatOk;
        end else begin
          r.status = StatInvalid;
        end
      end
      ActCheck: begin
        if (page_live(w.page_number)) begin
          r.result_page = w.page_number;
          r.status      = StatOk;
        end else begin
          r.status = StatInvalid;
        end
      end
      ActLast: begin
        // highest used slot below the count, else behave as allocate
        for (i = pg_count; i > 0; i--) begin
          if (used_map[i - 1]) begin
            r.result_page = PageW'(i);
            r.status      = StatOk;
            return r;
          end
        end
        r = take_page();
      end
      ActClear: begin
        used_map = '0;
        r.status = StatOk;
      end
      default: r.status = StatInvalid;
    endcase
    return r;
  endfunction

  // page number biased toward used pages and the count boundary
  function automatic logic [PageW-1:0] pick_page();
    int unsigned      roll;
    int unsigned      k;
    logic [PageW-1:0] p;
    roll = $urandom_range(0, 99);
    if (roll < 60 && pg_count > 0) begin
      p = PageW'($urandom_range(1, pg_count));
      for (k = 0; k < 8 && !used_map[p - 1]; k++) p = PageW'($urandom_range(1, pg_count));
    end else if (roll < 75) begin
      p = PageW'($urandom_range(0, pg_count));
    end else if (roll < 85) begin
      p = '0;
    end else if (roll < 95) begin
      p = PageW'(pg_count + $urandom_range(0, 1));
    end else begin
      p = PageW'($urandom_range(0, (1 << PageW) - 1));
    end
    return p;
  endfunction

  // random request, mostly well-formed, some noise
  function automatic in_word_t rand_word();
    in_word_t    w;
    int unsigned roll;
    roll          = $urandom_range(0, 99);
    w.page_number = pick_page();
    if (roll < 30)      w.action = ActAlloc;
    else if (roll < 50) w.action = ActFree;
    else if (roll < 70) w.action = ActCheck;
    else if (roll < 80) w.action = ActLast;
    else if (roll < 83) w.action = ActClear;
    else if (roll < 87) w.action = ActionW'($urandom_range(5, 7));
    else begin
      w.action      = ActionW'($urandom_range(0, 7));
      w.page_number = PageW'($urandom_range(0, (1 << PageW) - 1));
    end
    return w;
  endfunction

  function automatic in_word_t mk_word(logic [ActionW-1:0] a, logic [PageW-1:0] p);
    in_word_t w;
    w.action      = a;
    w.page_number = p;
    return w;
  endfunction

  // driver: present the oldest pending request, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word  <= '0;
      n_in     <= 0;
    end else begin
      if (in_valid && in_ready) begin
        resp_q.push_back(serve_request(in_word));
        void'(req_q.pop_front());
        n_in <= n_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (req_q.size() > 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid <= 1'b1;
          in_word  <= req_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compare each response with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      out_ready    <= 1'b0;
      mismatch_cnt <= 0;
      stall_cycles <= 0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (out_valid && out_ready) begin
        if (resp_q.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("unexpected response: page %0d appended %0d status %0d",
                     out_word.result_page, out_word.appended, out_word.status);
        end else begin
          exp_w = resp_q.pop_front();
          if (out_word.result_page !== exp_w.result_page ||
              out_word.appended !== exp_w.appended ||
              out_word.status !== exp_w.status) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display("mismatch: expected page %0d app %0d st %0d, got page %0d app %0d st %0d",
                       exp_w.result_page, exp_w.appended, exp_w.status,
                       out_word.result_page, out_word.appended, out_word.status);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    wait (rst_ni === 1'b1);
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int unsigned k;

    // directed: empty store, appends, reuse, bounds, clear, unknown actions
    req_q.push_back(mk_word(ActCheck, '0));
    req_q.push_back(mk_word(ActFree, 13'd1));
    req_q.push_back(mk_word(ActLast, '0));
    req_q.push_back(mk_word(ActAlloc, '0));
    req_q.push_back(mk_word(ActAlloc, 13'h1FFF));
    req_q.push_back(mk_word(ActCheck, 13'd3));
    req_q.push_back(mk_word(ActCheck, 13'd4));
    req_q.push_back(mk_word(ActFree, 13'd2));
    req_q.push_back(mk_word(ActCheck, 13'd2));
    req_q.push_back(mk_word(ActFree, 13'd2));
    req_q.push_back(mk_word(ActAlloc, '0));
    req_q.push_back(mk_word(ActLast, 13'h1FFF));
    req_q.push_back(mk_word(ActFree, 13'd3));
    req_q.push_back(mk_word(ActLast, '0));
    req_q.push_back(mk_word(ActClear, 13'h1FFF));
    req_q.push_back(mk_word(ActCheck, 13'd1));
    req_q.push_back(mk_word(ActLast, '0));
    req_q.push_back(mk_word(ActCheck, 13'h1FFF));
    req_q.push_back(mk_word(ActFree, '0));
    req_q.push_back(mk_word(ActionW'(5), 13'h1FFF));
    req_q.push_back(mk_word(ActionW'(6), 13'h1555));
    req_q.push_back(mk_word(ActionW'(7), 13'h0AAA));
    req_q.push_back(mk_word(ActAlloc, 13'h1555));
    req_q.push_back(mk_word(ActCheck, 13'd4));

    wait (rst_ni === 1'b1);

    // random mix while the count stays small
    for (k = 0; k < RandWords; k++) begin
      while (req_q.size() > 2) @(negedge clk_i);
      req_q.push_back(rand_word());
    end

    // top page and numbers past the count, then last-valid and allocation
    req_q.push_back(mk_word(ActAlloc, '0));
    req_q.push_back(mk_word(ActAlloc, 13'h1FFF));
    req_q.push_back(mk_word(ActCheck, PageW'(MaxPages)));
    req_q.push_back(mk_word(ActCheck, PageW'(MaxPages + 1)));
    req_q.push_back(mk_word(ActLast, '0));
    req_q.push_back(mk_word(ActFree, PageW'(MaxPages)));
    req_q.push_back(mk_word(ActLast, '0));
    req_q.push_back(mk_word(ActAlloc, '0));
    req_q.push_back(mk_word(ActAlloc, '0));

    // drain, then let the block settle
    while (req_q.size() != 0 || resp_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (mismatch_cnt == 0 && resp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
